[hw/rtl/stlp_pkg.sv]
// Shared types and constants of the string to long parser.
// Base codes, character codes, and the command and status structs that join
// the controller and the datapath. No dependencies.
`default_nettype none

package stlp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned DIGIT_W  = 4;

  typedef logic [CHAR_W-1:0]         char_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [DIGIT_W-1:0]        digit_t;

  // Number base codes, as written to the base select register.
  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_e;

  localparam base_e BASE_RESET = BASE_DEC;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_A_UP  = 8'h41;
  localparam char_t CH_F_UP  = 8'h46;
  localparam char_t CH_X_UP  = 8'h58;
  localparam char_t CH_A_LO  = 8'h61;
  localparam char_t CH_F_LO  = 8'h66;
  localparam char_t CH_X_LO  = 8'h78;

  // Largest octal and decimal digit value plus one.
  localparam digit_t OCT_LIMIT = 4'd8;
  localparam digit_t DEC_LIMIT = 4'd10;
  localparam digit_t HEX_LETTER_OFFSET = 4'd9;

  // Controller to datapath, one step per accepted byte.
  typedef struct packed {
    logic  restart;   // clear number state before this byte
    logic  accum;     // fold the digit into the magnitude
    logic  mark;      // record the count up to this byte
    logic  pos_adv;   // advance the byte position
    logic  emit;      // load the result register
    logic  neg;       // sign of the number being emitted
    base_e radix;     // base used for folding the digit
  } stlp_cmd_t;

  // Datapath to controller: class of the current byte.
  typedef struct packed {
    logic   blank;
    logic   minus;
    logic   plus;
    logic   zero;
    logic   ex;
    logic   hexdig;
    digit_t digit;
  } stlp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/stlp_if.sv]
// Valid/ready channel interfaces of the string to long parser:
// one for incoming bytes and one for parse results. Depends on stlp_pkg.
`default_nettype none

interface stlp_in_if;
  logic               valid;
  logic               ready;
  stlp_pkg::char_t    char_byte;
  logic               string_start;

  modport source (output valid, output char_byte, output string_start, input ready);
  modport sink   (input valid, input char_byte, input string_start, output ready);
endinterface

interface stlp_out_if;
  logic               valid;
  logic               ready;
  stlp_pkg::value_t   parsed_value;
  stlp_pkg::count_t   consumed_count;
  logic               overflowed;

  modport source (output valid, output parsed_value, output consumed_count,
                  output overflowed, input ready);
  modport sink   (input valid, input parsed_value, input consumed_count,
                  input overflowed, output ready);
endinterface

`default_nettype wire

[hw/rtl/string_to_long_parser.sv]
// Top level of the string to long parser: controller and datapath joined by
// command and status structs. Depends on stlp_pkg, stlp_if, stlp_ctrl and
// stlp_dpath.
//
//   channel   | dir | handshake   | payload
//   ----------+-----+-------------+---------------------------------------------
//   char_i    | in  | valid/ready | char_byte[7:0], string_start
//   result_o  | out | valid/ready | parsed_value[63:0] signed, consumed_count[11:0],
//             |     |             | overflowed
//   cfg       | in  | cfg_we_i    | cfg_wdata_i[1:0] base select
//
// Unless stalled, one byte is taken each cycle; the digit fold (shift, add,
// overflow check) completes in that same cycle through one multiply-by-base adder.
// A result appears on result_o the cycle after the byte that ends the number.
// A held result stalls char_i only when it is not taken in that cycle; the
// output register lets the next byte transfer while the result is taken.
// Reset puts the parser idle with decimal base; no clearing pass is needed.
`default_nettype none

module string_to_long_parser #(
  parameter int unsigned VALUE_BITS    = 64,
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  stlp_in_if.sink     char_i,
  stlp_out_if.source  result_o
);
  import stlp_pkg::*;

  localparam logic [VALUE_W-1:0] SAT_MAX =
    VALUE_W'((65'(1) << (VALUE_BITS - 1)) - 65'(1));
  localparam logic [VALUE_W-1:0] SAT_MIN = ~SAT_MAX;

  stlp_cmd_t  cmd;
  stlp_stat_t stat;

  // Sequencing: phase, base, sign, handshakes.
  stlp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (char_i.valid),
    .string_start_i (char_i.string_start),
    .in_ready_o     (char_i.ready),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Arithmetic, counters and the result register.
  stlp_dpath #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i.char_byte),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .value_o (result_o.parsed_value),
    .count_o (result_o.consumed_count),
    .ovf_o   (result_o.overflowed)
  );

  // A new result only follows a byte transfer.
  a_result_follows_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(char_i.valid && char_i.ready))
    else $error("result raised without a byte transfer");

  // An overflowed result carries a saturated value.
  a_overflow_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.overflowed) |->
      (result_o.parsed_value == SAT_MAX || result_o.parsed_value == SAT_MIN))
    else $error("overflow without saturated value");

  // A nonzero value needs at least one digit counted.
  a_value_has_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (POSITION_BITS <= COUNT_W && result_o.valid && result_o.parsed_value != '0) |->
      (result_o.consumed_count != '0))
    else $error("nonzero value with zero count");

endmodule

`default_nettype wire

[hw/rtl/stlp_dpath.sv]
// Datapath of the string to long parser: byte classification, magnitude
// accumulator with overflow detection, position counters, result register.
// Depends on stlp_pkg.
`default_nettype none

module stlp_dpath #(
  parameter int unsigned VALUE_BITS    = 64,
  parameter int unsigned POSITION_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stlp_pkg::char_t      char_i,
  input  stlp_pkg::stlp_cmd_t  cmd_i,
  output stlp_pkg::stlp_stat_t stat_o,
  output stlp_pkg::value_t     value_o,
  output stlp_pkg::count_t     count_o,
  output logic                 ovf_o
);
  import stlp_pkg::*;

  localparam int unsigned MAG_W  = VALUE_BITS - 1;
  localparam int unsigned PROD_W = MAG_W + 4;

  logic [MAG_W-1:0]         acc_q, acc_d, acc_cur;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_cur, pos_inc;
  logic [POSITION_BITS-1:0] mark_q, mark_d, mark_cur;
  logic                     ovf_q, ovf_d, ovf_cur;
  logic [PROD_W-1:0]        acc_ext, shifted, sum;
  logic                     ovf_now;
  logic [VALUE_BITS-1:0]    mag, val;
  value_t                   res_value_q;
  count_t                   res_count_q;
  logic                     res_ovf_q;

  // Byte classification.
  always_comb begin
    stat_o        = '0;
    stat_o.blank  = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
    stat_o.minus  = (char_i == CH_MINUS);
    stat_o.plus   = (char_i == CH_PLUS);
    stat_o.zero   = (char_i == CH_0);
    stat_o.ex     = (char_i == CH_X_LO) || (char_i == CH_X_UP);
    if ((char_i >= CH_0) && (char_i <= CH_9)) begin
      stat_o.hexdig = 1'b1;
      stat_o.digit  = char_i[DIGIT_W-1:0];
    end else if (((char_i >= CH_A_LO) && (char_i <= CH_F_LO)) ||
                 ((char_i >= CH_A_UP) && (char_i <= CH_F_UP))) begin
      stat_o.hexdig = 1'b1;
      stat_o.digit  = DIGIT_W'(char_i[DIGIT_W-1:0] + HEX_LETTER_OFFSET);
    end
  end

  assign acc_cur  = cmd_i.restart ? '0 : acc_q;
  assign pos_cur  = cmd_i.restart ? '0 : pos_q;
  assign mark_cur = cmd_i.restart ? '0 : mark_q;
  assign ovf_cur  = cmd_i.restart ? 1'b0 : ovf_q;

  assign pos_inc = (pos_cur == {POSITION_BITS{1'b1}}) ? pos_cur : pos_cur + 1'b1;

  // Multiply by the base as shifts (plus one add for decimal); the bits above the
  // magnitude width flag overflow.
  assign acc_ext = PROD_W'(acc_cur);
  always_comb begin
    case (cmd_i.radix)
      BASE_HEX: shifted = acc_ext << 4;
      BASE_OCT: shifted = acc_ext << 3;
      default:  shifted = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end
  assign sum     = shifted + PROD_W'(stat_o.digit);
  assign ovf_now = |sum[PROD_W-1:MAG_W];

  always_comb begin
    acc_d  = acc_cur;
    ovf_d  = ovf_cur;
    if (cmd_i.accum && !ovf_cur) begin
      if (ovf_now) begin
        ovf_d = 1'b1;
        acc_d = {MAG_W{1'b1}};
      end else begin
        acc_d = sum[MAG_W-1:0];
      end
    end
    mark_d = cmd_i.mark ? pos_inc : mark_cur;
    pos_d  = cmd_i.pos_adv ? pos_inc : pos_cur;
  end

  // Signed result at the configured width, saturated on overflow.
  assign mag = {1'b0, acc_cur};
  always_comb begin
    if (ovf_cur) begin
      val = cmd_i.neg ? {1'b1, {MAG_W{1'b0}}} : {1'b0, {MAG_W{1'b1}}};
    end else begin
      val = cmd_i.neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= '0;
      mark_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      mark_q <= mark_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_value_q <= VALUE_W'($signed(val));
      res_count_q <= COUNT_W'(mark_cur);
      res_ovf_q   <= ovf_cur;
    end
  end

  assign value_o = res_value_q;
  assign count_o = res_count_q;
  assign ovf_o   = res_ovf_q;

endmodule

`default_nettype wire

[hw/rtl/stlp_ctrl.sv]
// Controller of the string to long parser: parse phase machine, effective
// base, sign, base select register and the channel handshakes.
// Depends on stlp_pkg.
`default_nettype none

module stlp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 string_start_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  stlp_pkg::stlp_stat_t stat_i,
  output stlp_pkg::stlp_cmd_t  cmd_o
);
  import stlp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_e;

  phase_e    phase_q, phase_d, phase_cur;
  base_e     base_q, base_d, base_cur, base_sel_q;
  logic      neg_q, neg_d, neg_cur;
  logic      out_valid_q;
  logic      fire, first, take, digit_ok;
  stlp_cmd_t cmd;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign phase_cur = string_start_i ? PH_LEAD : phase_q;
  assign base_cur  = string_start_i ? base_sel_q : base_q;
  assign neg_cur   = string_start_i ? 1'b0 : neg_q;

  always_comb begin
    phase_d   = phase_cur;
    base_d    = base_cur;
    neg_d     = neg_cur;
    first     = 1'b0;
    take      = 1'b0;
    digit_ok  = 1'b0;
    cmd       = '0;
    cmd.restart = string_start_i;
    cmd.neg   = neg_cur;
    cmd.radix = base_cur;

    unique case (phase_cur)
      PH_IDLE: ;
      PH_LEAD: begin
        if (stat_i.blank) begin
        end else if (stat_i.minus) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (stat_i.plus) begin
          phase_d = PH_SIGNED;
        end else begin
          first = 1'b1;
        end
      end
      PH_SIGNED: first = 1'b1;
      PH_ZERO: begin
        if (stat_i.ex) begin
          base_d  = BASE_HEX;
          phase_d = PH_PREFIX;
        end else begin
          if (base_cur == BASE_AUTO) base_d = BASE_OCT;
          take = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: take = 1'b1;
      default: phase_d = PH_IDLE;
    endcase

    // A leading zero may open a prefix in automatic or hex base.
    if (first) begin
      if (stat_i.zero && (base_cur == BASE_AUTO || base_cur == BASE_HEX)) begin
        cmd.mark = 1'b1;
        phase_d  = PH_ZERO;
      end else begin
        if (base_cur == BASE_AUTO) base_d = BASE_DEC;
        take = 1'b1;
      end
    end

    // Take a digit below the base, or end the number.
    if (take) begin
      cmd.radix = base_d;
      unique case (base_d)
        BASE_HEX: digit_ok = stat_i.hexdig;
        BASE_OCT: digit_ok = stat_i.hexdig && (stat_i.digit < OCT_LIMIT);
        default:  digit_ok = stat_i.hexdig && (stat_i.digit < DEC_LIMIT);
      endcase
      if (digit_ok) begin
        cmd.accum = 1'b1;
        cmd.mark  = 1'b1;
        phase_d   = PH_DIGITS;
      end else begin
        cmd.emit = 1'b1;
        phase_d  = PH_IDLE;
      end
    end

    cmd.pos_adv = (phase_d != PH_IDLE);
  end

  assign cmd_o = fire ? cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      base_q      <= BASE_RESET;
      neg_q       <= 1'b0;
      base_sel_q  <= BASE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_sel_q <= base_e'(cfg_wdata_i);
      if (fire) begin
        phase_q <= phase_d;
        base_q  <= base_d;
        neg_q   <= neg_d;
      end
      if (fire && cmd.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
